### design/dstg_pkg.sv
// Package for the dual square tone generator.
// Holds register select codes, duty patterns, divider constants and the
// controller/datapath command and status types. No dependencies.
`default_nettype none

package dstg_pkg;

    // Register select codes
    localparam logic [2:0] REG_A_ENV     = 3'd0;
    localparam logic [2:0] REG_A_PER_LO  = 3'd1;
    localparam logic [2:0] REG_A_PER_HI  = 3'd2;
    localparam logic [2:0] REG_B_ENV     = 3'd3;
    localparam logic [2:0] REG_B_PER_LO  = 3'd4;
    localparam logic [2:0] REG_B_PER_HI  = 3'd5;

    // Item kinds
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Channel ids
    localparam logic CHAN_A = 1'b0;
    localparam logic CHAN_B = 1'b1;

    // Input clock of the tone source, and the dividend after folding in the
    // fixed divide-by-16: floor(floor(c/16)/(p+1)) == floor(c/(16*(p+1)))
    localparam int unsigned CLOCK_HZ = 1789773;
    localparam int unsigned DIV_NUM_INT = CLOCK_HZ / 16;
    localparam int DIV_BITS = $clog2(DIV_NUM_INT + 1);
    localparam int CNT_W = $clog2(DIV_BITS);
    localparam logic [DIV_BITS-1:0] DIV_NUM = DIV_BITS'(DIV_NUM_INT);

    // Period and divisor widths
    localparam int PER_W = 11;
    localparam int DVS_W = PER_W + 1;

    // Duty patterns, bit i is phase step i
    localparam logic [7:0] DUTY_PATTERN [4] = '{8'h01, 8'h03, 8'h0F, 8'h3F};

    // Controller to datapath commands
    typedef struct packed {
        logic wr_en;       // apply register write from the input item
        logic tick_start;  // capture the mixed level of both channels
        logic div_start;   // load the divider for channel div_chan
        logic div_step;    // one restoring step
        logic phase_upd;   // add quotient to phase of channel chan
        logic out_load;    // move the sum into the output register
        logic chan;        // channel for phase_upd
        logic div_chan;    // channel for div_start
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;    // current step is the final quotient bit
    } dp_stat_t;

endpackage

`default_nettype wire

### design/dstg_dp.sv
// Datapath of the dual square tone generator: channel registers, duty lookup,
// mixer, shared bit-serial divider and output register.
// Depends on dstg_pkg.
`default_nettype none

module dstg_dp #(
    parameter int PHASE_BITS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  dstg_pkg::dp_cmd_t   cmd,
    output dstg_pkg::dp_stat_t  stat,
    input  wire  [2:0]          reg_select,
    input  wire  [7:0]          write_data,
    output logic [5:0]          sample
);
    import dstg_pkg::*;

    // Channel state
    logic [PHASE_BITS-1:0] phase_reg [2];
    logic [PER_W-1:0]      period_reg [2];
    logic [3:0]            volume_reg [2];
    logic [1:0]            duty_reg [2];

    // Divider and mixer state
    logic [DVS_W-1:0]    dvs_reg;
    logic [DVS_W-1:0]    rem_reg;
    logic [DVS_W-1:0]    rem_next;
    logic [DIV_BITS-1:0] quo_reg;
    logic [DIV_BITS-1:0] quo_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [5:0]          sum_reg;
    logic [5:0]          sample_reg;

    logic [DVS_W:0]      trial;
    logic                qbit;
    logic [4:0]          level_a;
    logic [4:0]          level_b;
    logic [2:0]          step_a;
    logic [2:0]          step_b;

    // Duty lookup and level per channel
    assign step_a  = phase_reg[0][PHASE_BITS-1 -: 3];
    assign step_b  = phase_reg[1][PHASE_BITS-1 -: 3];
    assign level_a = DUTY_PATTERN[duty_reg[0]][step_a] ? {volume_reg[0], 1'b0} : 5'd0;
    assign level_b = DUTY_PATTERN[duty_reg[1]][step_b] ? {volume_reg[1], 1'b0} : 5'd0;

    // Restoring division step: next dividend bit comes from the constant
    assign trial    = {rem_reg, DIV_NUM[cnt_reg]};
    assign qbit     = (trial >= {1'b0, dvs_reg});
    assign rem_next = qbit ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
    assign quo_next = {quo_reg[DIV_BITS-2:0], qbit};

    assign stat.div_last = (cnt_reg == '0);

    // Channel registers: writes and phase advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                phase_reg[i]  <= '0;
                period_reg[i] <= '0;
                volume_reg[i] <= '0;
                duty_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.wr_en)
            begin
                unique case (reg_select)
                    REG_A_ENV:
                    begin
                        volume_reg[0] <= write_data[3:0];
                        duty_reg[0]   <= write_data[7:6];
                    end
                    REG_A_PER_LO: period_reg[0][7:0]  <= write_data;
                    REG_A_PER_HI: period_reg[0][10:8] <= write_data[2:0];
                    REG_B_ENV:
                    begin
                        volume_reg[1] <= write_data[3:0];
                        duty_reg[1]   <= write_data[7:6];
                    end
                    REG_B_PER_LO: period_reg[1][7:0]  <= write_data;
                    REG_B_PER_HI: period_reg[1][10:8] <= write_data[2:0];
                    default: ;  // unused selects are ignored
                endcase
            end
            if (cmd.phase_upd)
            begin
                phase_reg[cmd.chan] <= phase_reg[cmd.chan] + PHASE_BITS'(quo_reg);
            end
        end
    end

    // Divider, mix and output payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.tick_start)
        begin
            sum_reg <= {1'b0, level_a} + {1'b0, level_b};
        end
        if (cmd.div_start)
        begin
            dvs_reg <= {1'b0, period_reg[cmd.div_chan]} + DVS_W'(1);
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= CNT_W'(DIV_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            sample_reg <= sum_reg;
        end
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

### design/dstg_ctrl.sv
// Controller of the dual square tone generator: sequences register writes,
// the two divisions of a tick, and the output handshake.
// Depends on dstg_pkg.
`default_nettype none

module dstg_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 action,
    output logic                out_valid,
    input  wire                 out_ready,
    output dstg_pkg::dp_cmd_t   cmd,
    input  dstg_pkg::dp_stat_t  stat
);
    import dstg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       chan_reg;
    logic       chan_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.chan       = chan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        cmd.div_start  = 1'b1;
                        cmd.div_chan   = CHAN_A;
                        chan_next      = CHAN_A;
                        state_next     = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.phase_upd = 1'b1;
                if (chan_reg == CHAN_A)
                begin
                    state_next = S_DIV;
                    chan_next  = CHAN_B;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for a free output slot
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // second division is started from the update cycle of channel A
        if (state_reg == S_UPD && chan_reg == CHAN_A)
        begin
            cmd.div_start = 1'b1;
            cmd.div_chan  = CHAN_B;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= CHAN_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/dual_square_tone_generator.sv
// Dual square tone generator: two pulse channels mixed to one 6-bit sample.
// Top level; instantiates dstg_ctrl and dstg_dp, depends on dstg_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries action, reg_select, write_data.
//   action = 1 writes a channel register (envelope, period low, period high
//   for channel A at selects 0..2, channel B at 3..5; 6 and 7 are ignored)
//   and produces no output item. action = 0 is a sample tick that produces
//   one item on the output channel (out_valid/out_ready) carrying sample.
//   A register write leaves the controller idle, so in_ready stays high.
//   In a tick, the phase
//   increment of each channel comes from one shared restoring divider that
//   resolves one quotient bit per cycle (17 bits, twice per tick); each
//   channel then has a phase update state, and a last state loads the output.
//   No new item is accepted until a tick has loaded its output.
//   The output register holds a finished sample while the receiver stalls;
//   the next item is accepted meanwhile, and a following tick waits at its
//   end until the output register is free.
//   Reset clears phases, periods, volumes, duty selects and out_valid.
`default_nettype none

module dual_square_tone_generator #(
    parameter int PHASE_BITS = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire        action,
    input  wire  [2:0] reg_select,
    input  wire  [7:0] write_data,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [5:0] sample
);
    import dstg_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dstg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    dstg_dp #(
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .reg_select (reg_select),
        .write_data (write_data),
        .sample     (sample)
    );

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the dual square tone generator.
// Holds a scoreboard class that predicts mixed samples and the driving tasks.
// Depends on dstg_pkg and dual_square_tone_generator.
`timescale 1ns / 100ps

module testbench;
    import dstg_pkg::*;

    localparam int PHASE_W = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_ITEMS = 250;
    localparam logic [2:0] SEL_SPARE_LO = 3'd6;
    localparam logic [2:0] SEL_SPARE_HI = 3'd7;

    // Tone predictor and store of expected samples
    class tone_scoreboard;
        localparam int unsigned TONE_CLOCK = 1789773;
        localparam bit [31:0] DUTY_WAVES = 32'h3F0F0301;

        bit [PHASE_W-1:0] phase [2];
        bit [10:0] period [2];
        bit [3:0] volume [2];
        bit [1:0] duty [2];
        logic [5:0] expected_samples [$];
        int errors;

        function new();
            for (int ch = 0; ch < 2; ch++)
            begin
                phase[ch] = '0;
                period[ch] = '0;
                volume[ch] = '0;
                duty[ch] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        // One tick: level from the current phase, then advance the phase
        function logic [5:0] mix_tick();
            bit [7:0] wave;
            bit [2:0] step;
            int unsigned incr;
            bit [5:0] total;
            total = '0;
            for (int ch = 0; ch < 2; ch++)
            begin
                wave = DUTY_WAVES[duty[ch]*8 +: 8];
                step = phase[ch][PHASE_W-1 -: 3];
                if (wave[step])
                    total += {1'b0, volume[ch], 1'b0};
                incr = TONE_CLOCK / (16 * (int'(period[ch]) + 1));
                phase[ch] = phase[ch] + incr[PHASE_W-1:0];
            end
            return total;
        endfunction

        // Accepted input item: update register copies or queue a sample
        function void note_item(logic act, logic [2:0] sel, logic [7:0] data);
            int ch;
            if (act == ACT_TICK)
            begin
                expected_samples.push_back(mix_tick());
                return;
            end
            ch = (sel >= REG_B_ENV) ? 1 : 0;
            case (sel) inside
                REG_A_ENV, REG_B_ENV:
                begin
                    volume[ch] = data[3:0];
                    duty[ch] = data[7:6];
                end
                REG_A_PER_LO, REG_B_PER_LO:
                    period[ch][7:0] = data;
                REG_A_PER_HI, REG_B_PER_HI:
                    period[ch][10:8] = data[2:0];
                default:
                    ; // spare selects are ignored
            endcase
        endfunction

        // Accepted result against the oldest expectation
        function void check_sample(logic [5:0] actual);
            logic [5:0] want;
            if (expected_samples.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: sample %0d arrived with none expected", actual);
                return;
            end
            want = expected_samples.pop_front();
            if (actual !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: sample expected %0d, got %0d", want, actual);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic action;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic out_valid;
    logic out_ready;
    logic [5:0] sample;

    bit quiet;
    int cycles;
    tone_scoreboard tones = new();

    dual_square_tone_generator #(
        .PHASE_BITS(PHASE_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .reg_select(reg_select),
        .write_data(write_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sample(sample)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tones.check_sample(sample);
    end

    // Receiver: ready with random stall bursts, always ready in the quiet part
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge clk);
        end
    end

    // Present one item and hold it until accepted
    task automatic send_item(input logic act, input logic [2:0] sel, input logic [7:0] data);
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        reg_select <= sel;
        write_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tones.note_item(act, sel, data);
    endtask

    // Hold the input side idle for a number of cycles
    task automatic idle_input(input int span);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (span - 1) @(negedge clk);
    endtask

    task automatic drain_samples();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tones.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] sel, input logic [7:0] data);
        send_item(ACT_WRITE, sel, data);
    endtask

    task automatic tick();
        send_item(ACT_TICK, 3'($urandom), 8'($urandom));
    endtask

    // Random item: mostly ticks, writes biased toward short periods
    task automatic random_item(output bit counted);
        logic [2:0] sel;
        logic [7:0] data;
        counted = 1'b1;
        if ($urandom_range(0, 9) < 7)
        begin
            tick();
            return;
        end
        sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        data = 8'($urandom);
        if ((sel == REG_A_PER_HI || sel == REG_B_PER_HI) && $urandom_range(0, 1) == 0)
            data[2:0] = 3'd0;
        if (sel == SEL_SPARE_LO || sel == SEL_SPARE_HI)
            counted = 1'b0;
        write_reg(sel, data);
    endtask

    // Stimulus
    initial
    begin
        int done;
        bit counted;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACT_TICK;
        reg_select <= '0;
        write_data <= '0;
        quiet = 1'b0;
        cycles = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset state, register extremes, ignored bits, spare selects,
        // duty patterns 1 to 3, shortest period for phase wrap, longest period
        tick();
        write_reg(REG_A_ENV, 8'hFF);
        write_reg(REG_B_ENV, 8'hC0);
        write_reg(REG_B_ENV, 8'hFF);
        tick();
        write_reg(REG_A_PER_LO, 8'hFF);
        write_reg(REG_A_PER_HI, 8'hFF);
        tick();
        tick();
        write_reg(REG_B_PER_LO, 8'h00);
        write_reg(REG_B_PER_HI, 8'hF8);
        tick();
        write_reg(SEL_SPARE_LO, 8'hFF);
        write_reg(SEL_SPARE_HI, 8'h00);
        tick();
        write_reg(REG_A_ENV, 8'h40);
        write_reg(REG_A_ENV, 8'h85);
        write_reg(REG_B_ENV, 8'h4A);
        tick();
        write_reg(REG_A_PER_LO, 8'h00);
        write_reg(REG_A_PER_HI, 8'h00);
        tick();
        tick();
        drain_samples();

        // Random part
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            if (done == RANDOM_ITEMS / 2)
                drain_samples();
            if (done >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if (!quiet && $urandom_range(0, 4) == 0)
                idle_input($urandom_range(1, 10));
            random_item(counted);
            if (counted)
                done++;
        end

        drain_samples();
        repeat (60) @(posedge clk);
        if (tones.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
